// ===== rtl/core/kuz_pkg.sv =====
// ----------------------------------------------------------------------------
// kuz_pkg
// Types, tables and GF(2^8) helpers for the block cipher unit.
// ----------------------------------------------------------------------------
package kuz_pkg;

   localparam int KeyHalves = 20;

   typedef enum logic [1:0] {
      CMD_ENCRYPT = 2'd0,
      CMD_DECRYPT = 2'd1,
      CMD_LOAD    = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_SBOX,
      ST_LIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [4:0]  key_slot;
      logic [63:0] word_hi;
      logic [63:0] word_lo;
   } req_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
      logic        was_decrypt;
   } rsp_type;

   localparam logic [7:0] SBOX_FWD [256] = '{
      8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,
      8'd35,8'd197,8'd4,8'd77,8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
      8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,8'd249,8'd24,8'd101,8'd90,
      8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
      8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,
      8'd127,8'd212,8'd211,8'd31,8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
      8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,8'd181,8'd112,8'd14,8'd86,
      8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
      8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,
      8'd157,8'd158,8'd178,8'd177,8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
      8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,8'd223,8'd245,8'd36,8'd169,
      8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
      8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,
      8'd78,8'd51,8'd10,8'd74,8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
      8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,8'd173,8'd69,8'd70,8'd146,
      8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
      8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,
      8'd136,8'd217,8'd231,8'd137,8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
      8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,8'd32,8'd113,8'd103,8'd164,
      8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
      8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,
      8'd57,8'd75,8'd99,8'd182
   };

   localparam logic [7:0] LIN_COEF [16] = '{
      8'd148,8'd32,8'd133,8'd16,8'd194,8'd192,8'd1,8'd251,
      8'd1,8'd192,8'd194,8'd16,8'd133,8'd32,8'd148,8'd1
   };

   function automatic logic [7:0] sbox_inv(input logic [7:0] v);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 256; i++) begin
         if (SBOX_FWD[i] == v) r = 8'(i);
      end
      return r;
   endfunction

   localparam logic [7:0] GfPoly = 8'hc3;

   function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] acc;
      logic [7:0] a;
      acc = '0;
      a = x;
      for (int i = 0; i < 8; i++) begin
         if (y[i]) acc ^= a;
         a = a[7] ? ({a[6:0], 1'b0} ^ GfPoly) : {a[6:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

// ===== rtl/core/kuznyechik_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// kuznyechik_block_cipher_unit
// Iterative 128-bit block cipher core with loadable round keys.
// ----------------------------------------------------------------------------
// A block runs nine rounds of key add, byte substitution and linear layer,
// then a final key add; decryption runs the inverse steps in reverse order.
// The linear layer runs one R step per cycle, each step a GF(2^8)
// multiply-accumulate over all sixteen bytes. Key loads give no beat.
// The unit takes no request while a block is in flight or its result waits.
module kuznyechik_block_cipher_unit import kuz_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type     state_ff, state_in;
   logic [127:0]  blk_ff, blk_in;
   logic [3:0]    rnd_ff, rnd_in;
   logic [3:0]    step_ff, step_in;
   logic          dec_ff, dec_in;
   logic [63:0]   key_ff [KeyHalves];
   logic          accept;
   logic [4:0]    kidx;
   logic [127:0]  rkey;
   logic [7:0]    sb [16];
   logic [7:0]    lx;
   logic [127:0]  sbox_out;
   logic [127:0]  lin_out;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data = '{result_hi: blk_ff[127:64], result_lo: blk_ff[63:0],
                       was_decrypt: dec_ff};

   assign kidx = {rnd_ff, 1'b0};
   assign rkey = {key_ff[kidx], key_ff[kidx + 5'd1]};

   always_comb begin
      for (int j = 0; j < 16; j++) begin
         sb[j] = blk_ff[127 - 8 * j -: 8];
      end
      for (int j = 0; j < 16; j++) begin
         sbox_out[127 - 8 * j -: 8] = dec_ff ? sbox_inv(sb[j]) : SBOX_FWD[sb[j]];
      end
      lx = '0;
      if (!dec_ff) begin
         for (int j = 0; j < 16; j++) lx ^= gf_mul(sb[j], LIN_COEF[j]);
         lin_out = {lx, blk_ff[127:8]};
      end else begin
         lx = gf_mul(sb[0], LIN_COEF[15]);
         for (int j = 0; j < 15; j++) lx ^= gf_mul(sb[j + 1], LIN_COEF[j]);
         lin_out = {blk_ff[119:0], lx};
      end
   end

   always_comb begin
      state_in = state_ff;
      blk_in = blk_ff;
      rnd_in = rnd_ff;
      step_in = step_ff;
      dec_in = dec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.command == CMD_ENCRYPT ||
                           req_data.command == CMD_DECRYPT)) begin
               blk_in = {req_data.word_hi, req_data.word_lo};
               dec_in = (req_data.command == CMD_DECRYPT);
               rnd_in = (req_data.command == CMD_DECRYPT) ? 4'd9 : 4'd0;
               state_in = ST_KEY;
            end
         end
         ST_KEY: begin
            blk_in = blk_ff ^ rkey;
            step_in = '0;
            if (dec_ff) begin
               if (rnd_ff == 4'd0) state_in = ST_DONE;
               else begin
                  rnd_in = rnd_ff - 4'd1;
                  state_in = ST_LIN;
               end
            end else begin
               if (rnd_ff == 4'd9) state_in = ST_DONE;
               else state_in = ST_SBOX;
            end
         end
         ST_SBOX: begin
            blk_in = sbox_out;
            if (dec_ff) state_in = ST_KEY;
            else state_in = ST_LIN;
         end
         ST_LIN: begin
            blk_in = lin_out;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               if (dec_ff) state_in = ST_SBOX;
               else begin
                  rnd_in = rnd_ff + 4'd1;
                  state_in = ST_KEY;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff <= '0;
         step_ff <= '0;
         dec_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff <= rnd_in;
         step_ff <= step_in;
         dec_ff <= dec_in;
      end
      blk_ff <= blk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KeyHalves; i++) key_ff[i] <= '0;
      end else if (accept && req_data.command == CMD_LOAD &&
                   req_data.key_slot < 5'(KeyHalves)) begin
         key_ff[req_data.key_slot] <= req_data.word_hi;
      end
   end

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> rnd_ff <= 4'd9)
      else $error("round counter out of range");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(blk_ff))
      else $error("result lost while stalled");
   a_lin_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LIN && step_ff == 4'd15 |=> state_ff == ST_KEY || state_ff == ST_SBOX)
      else $error("bad linear layer exit");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_KEY |-> req_stall)
      else $error("request taken while busy");

endmodule

// ===== tb/kuznyechik_block_cipher_unit_test.sv =====
// ----------------------------------------------------------------------------
// kuznyechik_block_cipher_unit_test
// Self-checking bench: key loads, encrypt and decrypt blocks with random
// content and random idle gaps, each result checked against a local cipher
// model kept in step with the loaded round keys.
// ----------------------------------------------------------------------------
module kuznyechik_block_cipher_unit_test;
   import kuz_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   kuznyechik_block_cipher_unit dut (.*);

   always #5 clock = ~clock;

   logic [63:0] key_half [KeyHalves];
   rsp_type     pending_blocks [$];
   logic [7:0]  sbox_table [256];
   logic [7:0]  sbox_back [256];
   logic [7:0]  coef_table [16];
   int          errors = 0;
   int          blocks_sent = 0;
   int          loads_sent = 0;
   int          beats_checked = 0;
   int          hold_cycles = 0;
   bit          gaps_on = 1'b1;

   function automatic logic [7:0] field_mul(logic [7:0] x, logic [7:0] y);
      logic [7:0] acc;
      logic [7:0] a;
      acc = '0;
      a = x;
      for (int i = 0; i < 8; i++) begin
         if (y[i]) acc ^= a;
         a = a[7] ? ({a[6:0], 1'b0} ^ 8'hc3) : {a[6:0], 1'b0};
      end
      return acc;
   endfunction

   function automatic logic [127:0] mix_key(logic [127:0] s, int k);
      return s ^ {key_half[2*k], key_half[2*k+1]};
   endfunction

   function automatic logic [127:0] linear_fwd(logic [127:0] s);
      logic [7:0] b [16];
      logic [7:0] x;
      for (int j = 0; j < 16; j++) b[j] = s[127-8*j -: 8];
      for (int n = 0; n < 16; n++) begin
         x = '0;
         for (int j = 0; j < 16; j++) x ^= field_mul(b[j], coef_table[j]);
         for (int j = 15; j > 0; j--) b[j] = b[j-1];
         b[0] = x;
      end
      for (int j = 0; j < 16; j++) s[127-8*j -: 8] = b[j];
      return s;
   endfunction

   function automatic logic [127:0] linear_back(logic [127:0] s);
      logic [7:0] b [16];
      logic [7:0] x;
      logic [7:0] first;
      for (int j = 0; j < 16; j++) b[j] = s[127-8*j -: 8];
      for (int n = 0; n < 16; n++) begin
         first = b[0];
         for (int j = 0; j < 15; j++) b[j] = b[j+1];
         x = field_mul(first, coef_table[15]);
         for (int j = 0; j < 15; j++) x ^= field_mul(b[j], coef_table[j]);
         b[15] = x;
      end
      for (int j = 0; j < 16; j++) s[127-8*j -: 8] = b[j];
      return s;
   endfunction

   function automatic logic [127:0] cipher_block(logic [127:0] s, bit decrypt);
      if (!decrypt) begin
         for (int r = 0; r < 9; r++) begin
            s = mix_key(s, r);
            for (int j = 0; j < 16; j++) s[8*j +: 8] = sbox_table[s[8*j +: 8]];
            s = linear_fwd(s);
         end
         s = mix_key(s, 9);
      end else begin
         s = mix_key(s, 9);
         for (int r = 8; r >= 0; r--) begin
            s = linear_back(s);
            for (int j = 0; j < 16; j++) s[8*j +: 8] = sbox_back[s[8*j +: 8]];
            s = mix_key(s, r);
         end
      end
      return s;
   endfunction

   function automatic void predict_request(req_type q);
      rsp_type e;
      logic [127:0] o;
      case (q.command)
         CMD_LOAD: begin
            if (q.key_slot < KeyHalves) key_half[q.key_slot] = q.word_hi;
         end
         CMD_ENCRYPT, CMD_DECRYPT: begin
            o = cipher_block({q.word_hi, q.word_lo}, q.command == CMD_DECRYPT);
            e.result_hi = o[127:64];
            e.result_lo = o[63:0];
            e.was_decrypt = (q.command == CMD_DECRYPT);
            pending_blocks = {pending_blocks, e};
         end
         default: ;
      endcase
   endfunction

   function automatic int gap_length();
      if (!gaps_on) return 0;
      if ($urandom_range(9) < 6) return 0;
      if ($urandom_range(19) == 0) return $urandom_range(200, 40);
      return $urandom_range(4, 1);
   endfunction

   // valid stays up across back-to-back beats; it drops only for a gap
   task automatic send_request(cmd_type c, logic [4:0] slot, logic [63:0] hi, logic [63:0] lo);
      int g;
      req_type q;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      q.command = c;
      q.key_slot = slot;
      q.word_hi = hi;
      q.word_lo = lo;
      req_data <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_request(q);
      if (c == CMD_LOAD) loads_sent++;
      else if (c != CMD_NONE) blocks_sent++;
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic drain();
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0 && n < 400000) begin
         @(negedge clock);
         n++;
      end
      repeat (200) @(negedge clock);
   endtask

   // receiver: random stalls, or a long hold on request
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (gaps_on && $urandom_range(9) < 3) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_blocks.size() == 0) begin
            $error("unexpected beat %h", rsp_data);
            errors++;
         end else begin
            e = pending_blocks.pop_front();
            beats_checked++;
            if (rsp_data.result_hi !== e.result_hi) begin
               $error("result_hi expected %h actual %h", e.result_hi, rsp_data.result_hi);
               errors++;
            end
            if (rsp_data.result_lo !== e.result_lo) begin
               $error("result_lo expected %h actual %h", e.result_lo, rsp_data.result_lo);
               errors++;
            end
            if (rsp_data.was_decrypt !== e.was_decrypt) begin
               $error("was_decrypt expected %b actual %b", e.was_decrypt,
                      rsp_data.was_decrypt);
               errors++;
            end
         end
      end
   end

   task automatic test_zero_keys();
      send_request(CMD_ENCRYPT, 5'd0, '0, '0);
      send_request(CMD_DECRYPT, 5'd0, '0, '0);
      send_request(CMD_ENCRYPT, 5'd31, '1, '1);
      send_request(CMD_DECRYPT, 5'd31, '1, '1);
   endtask

   task automatic test_key_loads();
      for (int i = 0; i < KeyHalves; i++) send_request(CMD_LOAD, 5'(i), rand64(), rand64());
      send_request(CMD_LOAD, 5'd20, '1, '1);
      send_request(CMD_LOAD, 5'd31, '1, '0);
      send_request(CMD_NONE, 5'd3, '1, '1);
      send_request(CMD_ENCRYPT, 5'd0, 64'h1122334455667700, 64'hffeeddccbbaa9988);
      send_request(CMD_DECRYPT, 5'd0, '1, '0);
      send_request(CMD_ENCRYPT, 5'd0, '0, '1);
   endtask

   task automatic test_random_traffic();
      int pick;
      logic [63:0] pt_hi;
      logic [63:0] pt_lo;
      for (int i = 0; i < 880; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_request(CMD_ENCRYPT, 5'($urandom()), rand64(), rand64());
         end else if (pick < 80) begin
            send_request(CMD_DECRYPT, 5'($urandom()), rand64(), rand64());
         end else if (pick < 95) begin
            send_request(CMD_LOAD, 5'($urandom_range(KeyHalves - 1)), rand64(), rand64());
         end else if (pick < 98) begin
            send_request(CMD_LOAD, 5'($urandom_range(31, KeyHalves)), rand64(), rand64());
         end else begin
            send_request(CMD_NONE, 5'($urandom()), rand64(), rand64());
         end
         if (i % 50 == 0) begin
            pt_hi = rand64();
            pt_lo = rand64();
            send_request(CMD_ENCRYPT, 5'd0, pt_hi, pt_lo);
         end
      end
   endtask

   task automatic test_output_hold();
      gaps_on = 1'b0;
      hold_cycles = 800;
      for (int i = 0; i < 6; i++) send_request(CMD_ENCRYPT, 5'd0, rand64(), rand64());
      gaps_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < 256; i++) sbox_table[i] = SBOX_FWD[i];
      for (int i = 0; i < 256; i++) sbox_back[SBOX_FWD[i]] = 8'(i);
      for (int i = 0; i < 16; i++) coef_table[i] = LIN_COEF[i];
      for (int i = 0; i < KeyHalves; i++) key_half[i] = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_zero_keys();
      test_key_loads();
      test_output_hold();
      test_random_traffic();
      drain();
      $display("covered %0d blocks and %0d key loads, %0d beats checked",
               blocks_sent, loads_sent, beats_checked);
      if (errors == 0 && pending_blocks.size() == 0) begin
         $display("kuznyechik_block_cipher_unit: match");
      end else begin
         $display("kuznyechik_block_cipher_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("kuznyechik_block_cipher_unit: mismatch");
      $finish;
   end
endmodule
